[rtl/mm_pkg.sv]
// Shared types and constants for the matrix multiply block.
package mm_pkg;

    localparam int DIM_W   = 4;   // width of a size register
    localparam int IDX_W   = 3;   // width of a row or column index
    localparam int VALUE_W = 16;  // width of an input element value
    localparam int ACC_W   = 40;  // width of a dot product
    localparam int OP_W    = 2;

    localparam logic [OP_W-1:0] OP_WRITE_A = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE_B = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

    localparam logic [1:0] REG_ROWS_A     = 2'd0;
    localparam logic [1:0] REG_INNER_SIZE = 2'd1;
    localparam logic [1:0] REG_COLS_B     = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic [IDX_W-1:0]          elem_row;
        logic [IDX_W-1:0]          elem_col;
        logic signed [VALUE_W-1:0] elem_value;
    } in_word_t;

    typedef struct packed {
        logic [IDX_W-1:0]        out_row;
        logic [IDX_W-1:0]        out_col;
        logic signed [ACC_W-1:0] out_value;
        logic                    out_last;
    } out_word_t;

    // sizes after clamping to the store dimension
    typedef struct packed {
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] inner;
        logic [DIM_W-1:0] cols;
    } dims_t;

    typedef struct packed {
        logic             wr_a;
        logic             wr_b;
        logic             issue;
        logic             clear_acc;
        logic [IDX_W-1:0] row_idx;
        logic [IDX_W-1:0] col_idx;
        logic [IDX_W-1:0] inner_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
    } dp_status_t;

endpackage

[rtl/mm_cfg_regs.sv]
// APB size registers with clamping to the store dimension.
module mm_cfg_regs #(
    parameter int MAX_DIM = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output mm_pkg::dims_t        dims
);

    logic [mm_pkg::DIM_W-1:0] rows_a_reg;
    logic [mm_pkg::DIM_W-1:0] inner_size_reg;
    logic [mm_pkg::DIM_W-1:0] cols_b_reg;
    logic                     wr_en;
    logic [1:0]               reg_sel;

    localparam logic [mm_pkg::DIM_W-1:0] DIM_MAX = mm_pkg::DIM_W'(MAX_DIM);

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_a_reg     <= mm_pkg::DIM_RESET;
            inner_size_reg <= mm_pkg::DIM_RESET;
            cols_b_reg     <= mm_pkg::DIM_RESET;
        end else if (wr_en) begin
            unique case (reg_sel)
                mm_pkg::REG_ROWS_A:     rows_a_reg     <= pwdata[mm_pkg::DIM_W-1:0];
                mm_pkg::REG_INNER_SIZE: inner_size_reg <= pwdata[mm_pkg::DIM_W-1:0];
                mm_pkg::REG_COLS_B:     cols_b_reg     <= pwdata[mm_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            mm_pkg::REG_ROWS_A:     prdata = 32'(rows_a_reg);
            mm_pkg::REG_INNER_SIZE: prdata = 32'(inner_size_reg);
            mm_pkg::REG_COLS_B:     prdata = 32'(cols_b_reg);
            default:                prdata = '0;
        endcase
    end

    // saturate sizes above the store dimension
    assign dims.rows  = (rows_a_reg > DIM_MAX) ? DIM_MAX : rows_a_reg;
    assign dims.inner = (inner_size_reg > DIM_MAX) ? DIM_MAX : inner_size_reg;
    assign dims.cols  = (cols_b_reg > DIM_MAX) ? DIM_MAX : cols_b_reg;

endmodule

[rtl/mm_ctrl.sv]
// Sequencer: decodes input words and steps through rows, columns and inner index.
module mm_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  mm_pkg::dims_t      dims,
    input  logic               s_valid,
    output logic               s_ready,
    input  mm_pkg::in_word_t   s_word,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_last,
    output mm_pkg::dp_cmd_t    cmd,
    input  mm_pkg::dp_status_t status
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [mm_pkg::IDX_W-1:0] i_reg, i_next;
    logic [mm_pkg::IDX_W-1:0] j_reg, j_next;
    logic [mm_pkg::IDX_W-1:0] k_reg, k_next;

    logic                     s_fire;
    logic [mm_pkg::DIM_W-1:0] row_ext, col_ext;
    logic                     a_in_range, b_in_range;
    logic                     last_row, last_col, last_inner;
    logic                     start;
    logic                     clear;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign row_ext = mm_pkg::DIM_W'(s_word.elem_row);
    assign col_ext = mm_pkg::DIM_W'(s_word.elem_col);

    assign a_in_range = (row_ext < dims.rows) && (col_ext < dims.inner);
    assign b_in_range = (row_ext < dims.inner) && (col_ext < dims.cols);

    assign last_row   = (mm_pkg::DIM_W'(i_reg) == dims.rows - 4'd1);
    assign last_col   = (mm_pkg::DIM_W'(j_reg) == dims.cols - 4'd1);
    assign last_inner = (mm_pkg::DIM_W'(k_reg) == dims.inner - 4'd1);

    // empty result matrix: nothing to emit
    assign start = s_fire && (s_word.op == mm_pkg::OP_COMPUTE) &&
                   (dims.rows != '0) && (dims.cols != '0);

    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        clear      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    clear      = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (dims.inner == '0 || last_inner) begin
                    k_next     = '0;
                    state_next = ST_DRAIN;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!status.busy) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    if (last_row && last_col) begin
                        state_next = ST_IDLE;
                    end else begin
                        clear      = 1'b1;
                        state_next = ST_RUN;
                        if (last_col) begin
                            j_next = '0;
                            i_next = i_reg + 1'b1;
                        end else begin
                            j_next = j_reg + 1'b1;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    assign cmd.wr_a      = s_fire && (s_word.op == mm_pkg::OP_WRITE_A) && a_in_range;
    assign cmd.wr_b      = s_fire && (s_word.op == mm_pkg::OP_WRITE_B) && b_in_range;
    assign cmd.issue     = (state_reg == ST_RUN) && (dims.inner != '0);
    assign cmd.clear_acc = clear;
    assign cmd.row_idx   = i_reg;
    assign cmd.col_idx   = j_reg;
    assign cmd.inner_idx = k_reg;

    assign m_valid = (state_reg == ST_OUT);
    assign m_last  = last_row && last_col;

endmodule

[rtl/mm_datapath.sv]
// Element stores, multiplier and dot product accumulator.
module mm_datapath #(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  mm_pkg::in_word_t                s_word,
    input  mm_pkg::dp_cmd_t                 cmd,
    output mm_pkg::dp_status_t              status,
    output logic signed [mm_pkg::ACC_W-1:0] acc_value
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PROD_W = 2 * ELEM_WIDTH;
    localparam int EXT_W  = (PROD_W > mm_pkg::ACC_W) ? PROD_W : mm_pkg::ACC_W;

    logic signed [ELEM_WIDTH-1:0] mem_a [DEPTH];
    logic signed [ELEM_WIDTH-1:0] mem_b [DEPTH];

    logic signed [ELEM_WIDTH-1:0]    elem;
    logic [ADDR_W-1:0]               wr_addr, rd_addr_a, rd_addr_b;
    logic signed [ELEM_WIDTH-1:0]    a_rdata_reg, b_rdata_reg;
    logic                            rd_valid_reg;
    logic signed [PROD_W-1:0]        prod_reg;
    logic                            mul_valid_reg;
    logic signed [EXT_W-1:0]         prod_ext;
    logic signed [mm_pkg::ACC_W-1:0] acc_reg, acc_next;

    // wrap or extend to the element width
    assign elem    = ELEM_WIDTH'(s_word.elem_value);
    assign wr_addr = ADDR_W'(int'(s_word.elem_row) * MAX_DIM + int'(s_word.elem_col));
    assign rd_addr_a = ADDR_W'(int'(cmd.row_idx) * MAX_DIM + int'(cmd.inner_idx));
    assign rd_addr_b = ADDR_W'(int'(cmd.inner_idx) * MAX_DIM + int'(cmd.col_idx));

    always_ff @(posedge aclk) begin
        if (cmd.wr_a) begin
            mem_a[wr_addr] <= elem;
        end
        a_rdata_reg <= mem_a[rd_addr_a];
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_b) begin
            mem_b[wr_addr] <= elem;
        end
        b_rdata_reg <= mem_b[rd_addr_b];
    end

    always_ff @(posedge aclk) begin
        prod_reg <= a_rdata_reg * b_rdata_reg;
    end

    assign prod_ext = EXT_W'(prod_reg);

    always_comb begin
        acc_next = acc_reg;
        if (cmd.clear_acc) begin
            acc_next = '0;
        end else if (mul_valid_reg) begin
            acc_next = acc_reg + mm_pkg::ACC_W'(prod_ext);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg  <= 1'b0;
            mul_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg  <= cmd.issue;
            mul_valid_reg <= rd_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign status.busy = rd_valid_reg || mul_valid_reg;
    assign acc_value   = acc_reg;

endmodule

[rtl/matrix_multiply.sv]
// Top level of the matrix multiply block.
//
//  Port group | Direction | Handshake         | Word
//  s_         | in        | s_valid / s_ready | op, elem_row, elem_col, elem_value
//  m_         | out       | m_valid / m_ready | out_row, out_col, out_value, out_last
//  APB        | in/out    | psel / penable    | rows_a, inner_size, cols_b at 0x0, 0x4, 0x8
//
// An element write is stored at its handshake. A compute word steps, for each result
// element, through inner_size reads from the two stores, waits while the read,
// multiply and accumulate registers drain, and holds the result on m_word until
// m_ready is high. A zero inner_size issues no reads and gives a zero result.
// One multiplier serves every product.
// s_ready is low from a compute word until its last result is taken.
// Reset sets all three sizes to 8; store contents are undefined until written.
module matrix_multiply #(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mm_pkg::in_word_t  s_word,
    output logic              m_valid,
    input  logic              m_ready,
    output mm_pkg::out_word_t m_word,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    mm_pkg::dims_t                   dims;
    mm_pkg::dp_cmd_t                 cmd;
    mm_pkg::dp_status_t              status;
    logic                            m_last;
    logic signed [mm_pkg::ACC_W-1:0] acc_value;

    mm_cfg_regs #(
        .MAX_DIM (MAX_DIM)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .dims    (dims)
    );

    mm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .dims    (dims),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_last  (m_last),
        .cmd     (cmd),
        .status  (status)
    );

    mm_datapath #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_word    (s_word),
        .cmd       (cmd),
        .status    (status),
        .acc_value (acc_value)
    );

    assign m_word.out_row   = cmd.row_idx;
    assign m_word.out_col   = cmd.col_idx;
    assign m_word.out_value = acc_value;
    assign m_word.out_last  = m_last;

endmodule

[verif/tb_matrix_multiply.sv]
// Testbench for the matrix multiply block: directed table, then random load and compute runs.
module tb_matrix_multiply;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM     = 8;
    localparam int ITEM_TARGET = 230;
    localparam int MIN_RESULTS = 48;
    localparam int SETTLE      = 24;    // cycles for a compute word that emits nothing
    localparam int LONG_HOLD   = 300;
    localparam int WATCHDOG    = 4000;

    localparam logic [mm_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef enum logic [1:0] {FREE_FLOW, COIN_TOSS, EVERY_FOURTH, RARE_STALL} stall_style_t;

    typedef struct {
        mm_pkg::in_word_t                word;
        bit                              typed;
        logic signed [mm_pkg::ACC_W-1:0] typed_value;
    } stim_t;

    typedef struct {
        bit                       is_cfg;
        logic [1:0]               dim_reg;
        logic [mm_pkg::DIM_W-1:0] dim_val;
        stim_t                    stim;
    } plan_row_t;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    mm_pkg::in_word_t  s_word  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    mm_pkg::out_word_t m_word;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [3:0]        paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;

    // predictor state
    logic [mm_pkg::DIM_W-1:0]          dim_rows  = mm_pkg::DIM_RESET;
    logic [mm_pkg::DIM_W-1:0]          dim_inner = mm_pkg::DIM_RESET;
    logic [mm_pkg::DIM_W-1:0]          dim_cols  = mm_pkg::DIM_RESET;
    logic signed [mm_pkg::VALUE_W-1:0] a_elems [MAX_DIM*MAX_DIM];
    logic signed [mm_pkg::VALUE_W-1:0] b_elems [MAX_DIM*MAX_DIM];

    // elements loaded so far, tracked when words are queued
    bit a_written [MAX_DIM*MAX_DIM];
    bit b_written [MAX_DIM*MAX_DIM];

    stim_t             send_q[$];
    mm_pkg::out_word_t pending_products[$];
    plan_row_t         plan[$];

    logic [1:0] dim_regs [3] = '{mm_pkg::REG_ROWS_A, mm_pkg::REG_INNER_SIZE,
                                 mm_pkg::REG_COLS_B};
    logic [mm_pkg::OP_W-1:0] stray_ops [3] = '{mm_pkg::OP_WRITE_A, mm_pkg::OP_WRITE_B,
                                               OP_UNUSED};

    int errors           = 0;
    int words_taken      = 0;
    int products_seen    = 0;
    int useful_queued    = 0;
    int products_planned = 0;
    int settings_written = 0;
    int idle_cycles      = 0;

    matrix_multiply DUT (.*);

    always #5 aclk = ~aclk;

    function automatic int unsigned clamp_dim(logic [mm_pkg::DIM_W-1:0] v);
        return (v > MAX_DIM) ? MAX_DIM : v;
    endfunction

    // true when an element write falls inside the current sizes
    function automatic bit lands(mm_pkg::in_word_t w);
        int unsigned nr = clamp_dim(dim_rows);
        int unsigned nk = clamp_dim(dim_inner);
        int unsigned nc = clamp_dim(dim_cols);
        case (w.op)
            mm_pkg::OP_WRITE_A: return w.elem_row < nr && w.elem_col < nk;
            mm_pkg::OP_WRITE_B: return w.elem_row < nk && w.elem_col < nc;
            default:            return 1'b0;
        endcase
    endfunction

    function automatic void apply_word(mm_pkg::in_word_t w);
        int unsigned nr   = clamp_dim(dim_rows);
        int unsigned nk   = clamp_dim(dim_inner);
        int unsigned nc   = clamp_dim(dim_cols);
        int unsigned slot = w.elem_row * MAX_DIM + w.elem_col;
        logic signed [mm_pkg::ACC_W-1:0] acc;
        mm_pkg::out_word_t res;
        if (w.op == mm_pkg::OP_WRITE_A && lands(w)) begin
            a_elems[slot] = w.elem_value;
        end else if (w.op == mm_pkg::OP_WRITE_B && lands(w)) begin
            b_elems[slot] = w.elem_value;
        end else if (w.op == mm_pkg::OP_COMPUTE) begin
            for (int unsigned i = 0; i < nr; i++) begin
                for (int unsigned j = 0; j < nc; j++) begin
                    acc = '0;
                    for (int unsigned k = 0; k < nk; k++)
                        acc += a_elems[i*MAX_DIM+k] * b_elems[k*MAX_DIM+j];
                    res.out_row   = mm_pkg::IDX_W'(i);
                    res.out_col   = mm_pkg::IDX_W'(j);
                    res.out_value = acc;
                    res.out_last  = (i == nr - 1) && (j == nc - 1);
                    pending_products.push_back(res);
                end
            end
        end
    endfunction

    function automatic stim_t make_stim(logic [mm_pkg::OP_W-1:0] op,
                                        logic [mm_pkg::IDX_W-1:0] row,
                                        logic [mm_pkg::IDX_W-1:0] col,
                                        logic [mm_pkg::VALUE_W-1:0] value);
        stim_t item;
        item.word.op         = op;
        item.word.elem_row   = row;
        item.word.elem_col   = col;
        item.word.elem_value = value;
        item.typed           = 1'b0;
        item.typed_value     = '0;
        return item;
    endfunction

    function automatic plan_row_t cfg_row(logic [1:0] which, logic [mm_pkg::DIM_W-1:0] val);
        plan_row_t row;
        row.is_cfg  = 1'b1;
        row.dim_reg = which;
        row.dim_val = val;
        row.stim    = make_stim(OP_UNUSED, '0, '0, '0);
        return row;
    endfunction

    function automatic plan_row_t word_row(logic [mm_pkg::OP_W-1:0] op,
                                           logic [mm_pkg::IDX_W-1:0] row_idx,
                                           logic [mm_pkg::IDX_W-1:0] col_idx,
                                           logic [mm_pkg::VALUE_W-1:0] value);
        plan_row_t row;
        row.is_cfg  = 1'b0;
        row.dim_reg = mm_pkg::REG_ROWS_A;
        row.dim_val = '0;
        row.stim    = make_stim(op, row_idx, col_idx, value);
        return row;
    endfunction

    // compute on a one by one product whose single result is known by hand
    function automatic plan_row_t checked_row(logic signed [mm_pkg::ACC_W-1:0] value);
        plan_row_t row = word_row(mm_pkg::OP_COMPUTE, '0, '0, '0);
        row.stim.typed       = 1'b1;
        row.stim.typed_value = value;
        return row;
    endfunction

    function automatic void queue_word(stim_t item);
        int unsigned slot = item.word.elem_row * MAX_DIM + item.word.elem_col;
        if (item.word.op == mm_pkg::OP_WRITE_A && lands(item.word)) begin
            a_written[slot] = 1'b1;
            useful_queued++;
        end else if (item.word.op == mm_pkg::OP_WRITE_B && lands(item.word)) begin
            b_written[slot] = 1'b1;
            useful_queued++;
        end else if (item.word.op == mm_pkg::OP_COMPUTE) begin
            useful_queued++;
            products_planned += clamp_dim(dim_rows) * clamp_dim(dim_cols);
        end
        send_q.push_back(item);
    endfunction

    function automatic logic [mm_pkg::VALUE_W-1:0] rand_elem();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return '0;
            3:       return '1;
            default: return mm_pkg::VALUE_W'($urandom);
        endcase
    endfunction

    function automatic logic [mm_pkg::DIM_W-1:0] rand_dim();
        int unsigned pick = $urandom_range(0, 15);
        if (pick == 0)  return '0;
        if (pick < 4)   return 4'd1;
        if (pick < 10)  return mm_pkg::DIM_W'($urandom_range(2, 3));
        if (pick < 13)  return mm_pkg::DIM_W'($urandom_range(4, 7));
        if (pick == 13) return mm_pkg::DIM_W'(MAX_DIM);
        return mm_pkg::DIM_W'($urandom_range(9, 15));
    endfunction

    // load every element the next compute reads, refresh a few, add strays, then mostly compute
    function automatic void queue_product_run();
        int unsigned nr = clamp_dim(dim_rows);
        int unsigned nk = clamp_dim(dim_inner);
        int unsigned nc = clamp_dim(dim_cols);
        stim_t run[$];
        for (int unsigned i = 0; i < nr; i++)
            for (int unsigned k = 0; k < nk; k++)
                if (!a_written[i*MAX_DIM+k] || $urandom_range(0, 3) == 0)
                    run.push_back(make_stim(mm_pkg::OP_WRITE_A, mm_pkg::IDX_W'(i),
                                            mm_pkg::IDX_W'(k), rand_elem()));
        for (int unsigned k = 0; k < nk; k++)
            for (int unsigned j = 0; j < nc; j++)
                if (!b_written[k*MAX_DIM+j] || $urandom_range(0, 3) == 0)
                    run.push_back(make_stim(mm_pkg::OP_WRITE_B, mm_pkg::IDX_W'(k),
                                            mm_pkg::IDX_W'(j), rand_elem()));
        repeat ($urandom_range(0, 2))
            run.push_back(make_stim(stray_ops[$urandom_range(0, 2)],
                                    mm_pkg::IDX_W'($urandom), mm_pkg::IDX_W'($urandom),
                                    mm_pkg::VALUE_W'($urandom)));
        run.shuffle();
        foreach (run[n])
            queue_word(run[n]);
        // leave some runs as bare loads
        if ($urandom_range(0, 7) != 0)
            queue_word(make_stim(mm_pkg::OP_COMPUTE, mm_pkg::IDX_W'($urandom),
                                 mm_pkg::IDX_W'($urandom), mm_pkg::VALUE_W'($urandom)));
    endfunction

    function automatic void check_field(string what, logic [mm_pkg::ACC_W-1:0] want,
                                        logic [mm_pkg::ACC_W-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
        end
    endfunction

    task automatic read_dim(input logic [1:0] which, input logic [mm_pkg::DIM_W-1:0] want);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {which, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== 32'(want)) begin
            errors++;
            $display("%0t: size register at %0h expected %0h, got %0h",
                     $time, {which, 2'b00}, want, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_dim(input logic [1:0] which, input logic [mm_pkg::DIM_W-1:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= 32'(val);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (which)
            mm_pkg::REG_ROWS_A:     dim_rows  = val;
            mm_pkg::REG_INNER_SIZE: dim_inner = val;
            mm_pkg::REG_COLS_B:     dim_cols  = val;
            default: ;
        endcase
        settings_written++;
        read_dim(which, val);
    endtask

    // wait until every queued word is taken and every product has come out
    task automatic drain();
        do @(posedge aclk);
        while (send_q.size() != 0 || s_valid || pending_products.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    initial begin : word_source
        stim_t             cur;
        mm_pkg::out_word_t fixed_res;
        int                burst_left;
        int                gap_left;
        int                depth;
        burst_left = 0;
        gap_left   = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && s_valid && s_ready) begin
                depth = pending_products.size();
                apply_word(cur.word);
                if (cur.typed) begin
                    // replace the predicted word with the one written in the table
                    while (pending_products.size() > depth)
                        void'(pending_products.pop_back());
                    fixed_res.out_row   = '0;
                    fixed_res.out_col   = '0;
                    fixed_res.out_value = cur.typed_value;
                    fixed_res.out_last  = 1'b1;
                    pending_products.push_back(fixed_res);
                end
                words_taken++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (send_q.size() != 0) begin
                    cur = send_q.pop_front();
                    s_word  <= cur.word;
                    s_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 15);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    initial begin : result_sink
        stall_style_t      style;
        mm_pkg::out_word_t want;
        int                stretch_left;
        int                hold_left;
        bit                held_long;
        style        = FREE_FLOW;
        stretch_left = 0;
        hold_left    = 0;
        held_long    = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                products_seen++;
                if (pending_products.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result word row %0d col %0d value %0h last %0b",
                             $time, m_word.out_row, m_word.out_col, m_word.out_value,
                             m_word.out_last);
                end else begin
                    want = pending_products.pop_front();
                    check_field("out_row", want.out_row, m_word.out_row);
                    check_field("out_col", want.out_col, m_word.out_col);
                    check_field("out_value", want.out_value, m_word.out_value);
                    check_field("out_last", want.out_last, m_word.out_last);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!held_long && m_valid && products_seen >= 16 && send_q.size() != 0) begin
                // hold off long enough for the input side to back up behind the compute
                held_long = 1'b1;
                hold_left = LONG_HOLD;
                m_ready <= 1'b0;
            end else begin
                if (stretch_left == 0) begin
                    style        = stall_style_t'($urandom_range(0, 3));
                    stretch_left = $urandom_range(8, 60);
                end
                stretch_left--;
                case (style)
                    FREE_FLOW:    m_ready <= 1'b1;
                    COIN_TOSS:    m_ready <= 1'($urandom_range(0, 1));
                    EVERY_FOURTH: m_ready <= (stretch_left % 4) != 0;
                    default:      m_ready <= $urandom_range(0, 7) != 0;
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG);
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (dim_regs[n])
            read_dim(dim_regs[n], mm_pkg::DIM_RESET);

        plan = '{
            cfg_row(mm_pkg::REG_ROWS_A, 4'd1),
            cfg_row(mm_pkg::REG_INNER_SIZE, 4'd1),
            cfg_row(mm_pkg::REG_COLS_B, 4'd1),
            word_row(mm_pkg::OP_WRITE_A, 3'd0, 3'd0, 16'h8000),
            word_row(mm_pkg::OP_WRITE_B, 3'd0, 3'd0, 16'h8000),
            checked_row(40'sh00_4000_0000),
            word_row(mm_pkg::OP_WRITE_B, 3'd0, 3'd0, 16'h7fff),
            checked_row(40'shff_c000_8000),
            word_row(mm_pkg::OP_WRITE_A, 3'd0, 3'd0, 16'h7fff),
            checked_row(40'sh00_3fff_0001),
            // writes outside the sizes and the unused op must leave the stores alone
            word_row(mm_pkg::OP_WRITE_A, 3'd7, 3'd7, 16'h0000),
            word_row(mm_pkg::OP_WRITE_B, 3'd1, 3'd0, 16'h1234),
            word_row(mm_pkg::OP_WRITE_B, 3'd0, 3'd7, 16'hffff),
            word_row(OP_UNUSED, 3'd5, 3'd2, 16'ha5a5),
            checked_row(40'sh00_3fff_0001),
            cfg_row(mm_pkg::REG_ROWS_A, 4'd0),
            word_row(mm_pkg::OP_WRITE_A, 3'd0, 3'd0, 16'h1234),
            word_row(mm_pkg::OP_COMPUTE, 3'd0, 3'd0, 16'h0000),
            cfg_row(mm_pkg::REG_ROWS_A, 4'd1),
            checked_row(40'sh00_3fff_0001),
            cfg_row(mm_pkg::REG_INNER_SIZE, 4'd0),
            checked_row('0),
            cfg_row(mm_pkg::REG_INNER_SIZE, 4'd1),
            cfg_row(mm_pkg::REG_COLS_B, 4'd0),
            word_row(mm_pkg::OP_COMPUTE, 3'd7, 3'd7, 16'hffff),
            cfg_row(mm_pkg::REG_COLS_B, 4'd1),
            word_row(mm_pkg::OP_WRITE_A, 3'd0, 3'd0, 16'h0180),
            word_row(mm_pkg::OP_WRITE_B, 3'd0, 3'd0, 16'hff80),
            word_row(mm_pkg::OP_COMPUTE, 3'd0, 3'd0, 16'h0000)
        };
        foreach (plan[n]) begin
            if (plan[n].is_cfg) begin
                drain();
                set_dim(plan[n].dim_reg, plan[n].dim_val);
            end else begin
                queue_word(plan[n].stim);
            end
        end

        for (int phase = 0; useful_queued < ITEM_TARGET || products_planned < MIN_RESULTS;
             phase++) begin
            if (phase == 1) begin
                // full eight by eight result, columns above the store size
                drain();
                set_dim(mm_pkg::REG_ROWS_A, mm_pkg::DIM_W'(MAX_DIM));
                set_dim(mm_pkg::REG_INNER_SIZE, 4'd2);
                set_dim(mm_pkg::REG_COLS_B, 4'd15);
            end else if ($urandom_range(0, 2) == 0) begin
                drain();
                repeat ($urandom_range(1, 3))
                    set_dim(dim_regs[$urandom_range(0, 2)], rand_dim());
            end
            queue_product_run();
            while (send_q.size() > 16)
                @(posedge aclk);
        end
        drain();

        $display("Ran %0d input words across %0d size register writes, %0d product words checked.",
                 words_taken, settings_written, products_seen);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[matrix_multiply.f]
rtl/mm_pkg.sv
rtl/mm_cfg_regs.sv
rtl/mm_ctrl.sv
rtl/mm_datapath.sv
rtl/matrix_multiply.sv
verif/tb_matrix_multiply.sv
